@@ src/rtm_pkg.sv @@
// Shared constants, table entry layouts and helpers of the RTT matcher.
package rtm_pkg;

    localparam int FLOW_ENTRIES  = 1024;
    localparam int STAMP_ENTRIES = 4096;
    localparam int FLOW_AW       = $clog2(FLOW_ENTRIES);
    localparam int STAMP_AW      = $clog2(STAMP_ENTRIES);
    localparam int CNT_W         = FLOW_AW + 1;

    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_RTT      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_UNIDIR   = 3'd3;
    localparam logic [2:0] ST_NO_TS    = 3'd4;
    localparam logic [2:0] ST_NO_MATCH = 3'd5;
    localparam logic [2:0] ST_CLEANUP  = 3'd6;

    localparam logic [2:0] CFG_LOCAL_EN   = 3'd0;
    localparam logic [2:0] CFG_LOCAL_BASE = 3'd1;
    localparam logic [2:0] CFG_LOCAL_MASK = 3'd2;
    localparam logic [2:0] CFG_TS_AGE     = 3'd3;
    localparam logic [2:0] CFG_FLOW_IDLE  = 3'd4;
    localparam logic [2:0] CFG_FLOW_LIMIT = 3'd5;

    typedef struct packed {
        logic                valid;
        logic [63:0]         addrs;
        logic [31:0]         ports;
        logic                bidir;
        logic [47:0]         last_seen;
        logic [31:0]         min_rtt;
        logic [47:0]         bytes_sent;
        logic [47:0]         bytes_at_sample;
        logic [47:0]         bytes_departed;
    } t_flow_word;

    typedef struct packed {
        logic                valid;
        logic                used;
        logic [FLOW_AW-1:0]  flow;
        logic [31:0]         tsval;
        logic [47:0]         stime;
        logic [47:0]         fwd_bytes;
        logic [47:0]         dep_bytes;
    } t_stamp_word;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {33'd0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic logic aged(input logic [47:0] now_v, input logic [47:0] then_v,
                                  input logic [31:0] lim);
        logic [47:0] d;
        d = now_v - then_v;
        return (now_v > then_v) && (d > {16'd0, lim});
    endfunction

endpackage

@@ src/rtm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module rtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/passive_tcp_rtt_matcher.sv @@
// Top level of the passive TCP timestamp RTT matcher.
// One request at a time. A packet request that reaches the stamp table (timestamp option on a
// bidirectional flow) scans the whole flow table and then the whole stamp table; one that stops
// at the flow table (unidirectional flow or table full) scans only the flow table, and one
// without a usable timestamp scans neither table. A cleanup tick scans the flow table and then
// the stamp table, passing through the extra state S_CS_CK2 for each valid stamp entry. Each
// table is walked one entry at a time through the single read port of its RAM. After reset a
// clearing pass wipes both tables before the first request is taken; configuration writes are
// taken at any time.
module passive_tcp_rtt_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [47:0] i_now_us,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_ts_value,
    input  logic [31:0] i_ts_echo,
    input  logic        i_syn_only,
    input  logic        i_has_timestamp,
    input  logic [15:0] i_packet_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_flow_slot,
    output logic [31:0] o_rtt_us,
    output logic [31:0] o_min_rtt_us,
    output logic [47:0] o_fwd_bytes,
    output logic [47:0] o_departed_bytes,
    output logic [47:0] o_bytes_since_sample,
    output logic [10:0] o_removed_count
);

    localparam int FAW = rtm_pkg::FLOW_AW;
    localparam int SAW = rtm_pkg::STAMP_AW;
    localparam int CW  = rtm_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PKT, S_F_RD, S_F_CK, S_F_DEC, S_F_BID,
        S_S_RD, S_S_CK, S_S_DEC, S_WR_NS, S_RTT, S_SMP, S_WR_F, S_WR_R,
        S_CF_RD, S_CF_CK, S_CS_RD, S_CS_CK, S_CS_CK2, S_DONE
    } t_state;

    t_state r_state;
    logic [SAW-1:0] r_idx;

    logic        r_cfg_local_en;
    logic [31:0] r_cfg_base, r_cfg_mask, r_cfg_ts_age, r_cfg_idle;
    logic [10:0] r_cfg_limit;
    logic [CW-1:0] r_flow_count;

    logic        r_syn, r_hasts;
    logic [47:0] r_now;
    logic [31:0] r_sa, r_da, r_tsv, r_ecr;
    logic [15:0] r_sp, r_dp, r_len;

    logic                r_f_found, r_r_found, r_free_found, r_rw_dirty;
    logic [FAW-1:0]      r_f, r_r, r_free;
    rtm_pkg::t_flow_word r_fw, r_rw;

    logic                 r_rec, r_m1, r_m2, r_sfree_found, r_ins, r_sample;
    logic [SAW-1:0]       r_s, r_sfree;
    rtm_pkg::t_stamp_word r_sw;
    logic [47:0]          r_arr;
    logic [31:0]          r_rtt;

    logic [2:0]  r_res_status;
    logic [9:0]  r_res_slot;
    logic [31:0] r_res_rtt, r_res_min;
    logic [47:0] r_res_fwd, r_res_dep, r_res_since;
    logic [10:0] r_removed;

    logic        r_o_valid;
    logic [2:0]  r_o_status;
    logic [9:0]  r_o_slot;
    logic [31:0] r_o_rtt, r_o_min;
    logic [47:0] r_o_fwd, r_o_dep, r_o_since;
    logic [10:0] r_o_removed;

    // table ports
    logic                 w_fwe, w_swe;
    logic [FAW-1:0]       w_fwaddr, w_fraddr;
    logic [SAW-1:0]       w_swaddr;
    rtm_pkg::t_flow_word  w_fwdata, w_frd;
    rtm_pkg::t_stamp_word w_swdata, w_srd;

    rtm_ram #(.WIDTH($bits(rtm_pkg::t_flow_word)), .DEPTH(rtm_pkg::FLOW_ENTRIES)) u_flow_ram (
        .i_clk  (i_clk),
        .i_we   (w_fwe),
        .i_waddr(w_fwaddr),
        .i_wdata(w_fwdata),
        .i_raddr(w_fraddr),
        .o_rdata(w_frd)
    );

    rtm_ram #(.WIDTH($bits(rtm_pkg::t_stamp_word)), .DEPTH(rtm_pkg::STAMP_ENTRIES)) u_stamp_ram (
        .i_clk  (i_clk),
        .i_we   (w_swe),
        .i_waddr(w_swaddr),
        .i_wdata(w_swdata),
        .i_raddr(r_idx),
        .o_rdata(w_srd)
    );

    logic                 w_accept, w_self, w_key_hit, w_rev_hit, w_fkill, w_skill;
    logic                 w_ins, w_special, w_ovl;
    logic [CW-1:0]        w_lim;
    logic [47:0]          w_arr, w_diff;
    logic [31:0]          w_min;
    logic                 w_flow_last, w_stamp_last;
    rtm_pkg::t_stamp_word w_ns;

    assign w_accept     = i_valid && o_ready;
    assign w_self       = (r_sa == r_da) && (r_sp == r_dp);
    assign w_key_hit    = w_frd.valid && (w_frd.addrs == {r_sa, r_da})
                          && (w_frd.ports == {r_sp, r_dp});
    assign w_rev_hit    = w_frd.valid && (w_frd.addrs == {r_da, r_sa})
                          && (w_frd.ports == {r_dp, r_sp});
    assign w_lim        = (r_cfg_limit > CW'(rtm_pkg::FLOW_ENTRIES))
                          ? CW'(rtm_pkg::FLOW_ENTRIES) : r_cfg_limit;
    assign w_arr        = rtm_pkg::sat_add48(r_fw.bytes_sent, r_len);
    assign w_fkill      = w_frd.valid && rtm_pkg::aged(r_now, w_frd.last_seen, r_cfg_idle);
    assign w_skill      = rtm_pkg::aged(r_now, r_sw.stime, r_cfg_ts_age) || !w_frd.valid;
    assign w_flow_last  = (r_idx == SAW'(rtm_pkg::FLOW_ENTRIES - 1));
    assign w_stamp_last = (r_idx == SAW'(rtm_pkg::STAMP_ENTRIES - 1));
    assign w_ins        = r_rec && !r_m1 && r_sfree_found;
    // a new stamp of a self-reverse flow can be the echo match of the same packet
    assign w_special    = w_ins && r_r_found && (r_r == r_f) && (r_ecr == r_tsv);
    assign w_diff       = r_now - r_sw.stime;
    assign w_ovl        = (w_diff[47:32] != 16'd0);
    assign w_min        = (r_fw.min_rtt > r_rtt) ? r_rtt : r_fw.min_rtt;

    always_comb begin
        w_ns           = '0;
        w_ns.valid     = 1'b1;
        w_ns.used      = 1'b0;
        w_ns.flow      = r_f;
        w_ns.tsval     = r_tsv;
        w_ns.stime     = r_now;
        w_ns.fwd_bytes = r_arr;
        w_ns.dep_bytes = r_fw.bytes_departed;
    end

    always_comb begin
        w_fraddr = (r_state == S_CS_CK) ? w_srd.flow : r_idx[FAW-1:0];
        w_fwe    = 1'b0;
        w_fwaddr = r_idx[FAW-1:0];
        w_fwdata = '0;
        w_swe    = 1'b0;
        w_swaddr = r_idx;
        w_swdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_fwe = ({1'b0, r_idx} < (SAW + 1)'(rtm_pkg::FLOW_ENTRIES));
                w_swe = 1'b1;
            end
            S_CF_CK: begin
                w_fwe          = w_fkill;
                w_fwdata       = w_frd;
                w_fwdata.valid = 1'b0;
            end
            S_CS_CK2: begin
                w_swe          = w_skill;
                w_swdata       = r_sw;
                w_swdata.valid = 1'b0;
            end
            S_WR_NS: begin
                w_swe    = r_ins;
                w_swaddr = r_sfree;
                w_swdata = w_ns;
            end
            S_SMP: begin
                w_swe         = 1'b1;
                w_swaddr      = r_s;
                w_swdata      = r_sw;
                w_swdata.used = 1'b1;
            end
            S_WR_F: begin
                w_fwe    = 1'b1;
                w_fwaddr = r_f;
                w_fwdata = r_fw;
            end
            S_WR_R: begin
                w_fwe    = r_rw_dirty && r_r_found && (r_r != r_f);
                w_fwaddr = r_r;
                w_fwdata = r_rw;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_idx          <= '0;
            r_o_valid      <= 1'b0;
            r_flow_count   <= '0;
            r_cfg_local_en <= 1'b1;
            r_cfg_base     <= 32'd0;
            r_cfg_mask     <= 32'd0;
            r_cfg_ts_age   <= 32'd10000000;
            r_cfg_idle     <= 32'd300000000;
            r_cfg_limit    <= 11'd1024;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rtm_pkg::CFG_LOCAL_EN:   r_cfg_local_en <= i_cfg_data[0];
                    rtm_pkg::CFG_LOCAL_BASE: r_cfg_base     <= i_cfg_data;
                    rtm_pkg::CFG_LOCAL_MASK: r_cfg_mask     <= i_cfg_data;
                    rtm_pkg::CFG_TS_AGE:     r_cfg_ts_age   <= i_cfg_data;
                    rtm_pkg::CFG_FLOW_IDLE:  r_cfg_idle     <= i_cfg_data;
                    rtm_pkg::CFG_FLOW_LIMIT: r_cfg_limit    <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end

            if (r_o_valid && i_ready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (w_stamp_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_now        <= i_now_us;
                        r_sa         <= i_src_ip;
                        r_da         <= i_dst_ip;
                        r_sp         <= i_src_port;
                        r_dp         <= i_dst_port;
                        r_tsv        <= i_ts_value;
                        r_ecr        <= i_ts_echo;
                        r_syn        <= i_syn_only;
                        r_hasts      <= i_has_timestamp;
                        r_len        <= i_packet_length;
                        r_res_status <= rtm_pkg::ST_IGNORED;
                        r_res_slot   <= '0;
                        r_res_rtt    <= '0;
                        r_res_min    <= '0;
                        r_res_fwd    <= '0;
                        r_res_dep    <= '0;
                        r_res_since  <= '0;
                        r_removed    <= '0;
                        r_idx        <= '0;
                        r_state      <= i_opcode ? S_CF_RD : S_PKT;
                    end
                end
                S_PKT: begin
                    r_f_found    <= 1'b0;
                    r_r_found    <= 1'b0;
                    r_free_found <= 1'b0;
                    r_rw_dirty   <= 1'b0;
                    if (!r_hasts) begin
                        r_res_status <= rtm_pkg::ST_NO_TS;
                        r_state      <= S_DONE;
                    end else if (r_tsv == 32'd0 || (r_ecr == 32'd0 && !r_syn)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_F_RD;
                    end
                end
                S_F_RD: r_state <= S_F_CK;
                S_F_CK: begin
                    if (w_key_hit && !r_f_found) begin
                        r_f_found <= 1'b1;
                        r_f       <= r_idx[FAW-1:0];
                        r_fw      <= w_frd;
                    end
                    if (w_rev_hit && !r_r_found) begin
                        r_r_found <= 1'b1;
                        r_r       <= r_idx[FAW-1:0];
                        r_rw      <= w_frd;
                    end
                    if (!w_frd.valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free       <= r_idx[FAW-1:0];
                    end
                    if (w_flow_last) begin
                        r_state <= S_F_DEC;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_F_RD;
                    end
                end
                S_F_DEC: begin
                    if (r_f_found) begin
                        r_state <= S_F_BID;
                    end else if (r_flow_count >= w_lim || !r_free_found) begin
                        r_res_status <= rtm_pkg::ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_f                  <= r_free;
                        r_fw.valid           <= 1'b1;
                        r_fw.addrs           <= {r_sa, r_da};
                        r_fw.ports           <= {r_sp, r_dp};
                        r_fw.bidir           <= r_r_found || w_self;
                        r_fw.min_rtt         <= 32'hFFFF_FFFF;
                        r_fw.bytes_sent      <= '0;
                        r_fw.bytes_at_sample <= '0;
                        r_fw.bytes_departed  <= '0;
                        r_flow_count         <= r_flow_count + 1'b1;
                        if (w_self) begin
                            r_r_found <= 1'b1;
                            r_r       <= r_free;
                        end else if (r_r_found) begin
                            r_rw.bidir <= 1'b1;
                            r_rw_dirty <= 1'b1;
                        end
                        r_state <= S_F_BID;
                    end
                end
                S_F_BID: begin
                    r_fw.last_seen <= r_now;
                    r_res_slot     <= 10'(r_f);
                    if (!r_fw.bidir) begin
                        r_res_status <= rtm_pkg::ST_UNIDIR;
                        r_state      <= S_WR_F;
                    end else begin
                        r_res_status    <= rtm_pkg::ST_NO_MATCH;
                        r_arr           <= w_arr;
                        r_fw.bytes_sent <= w_arr;
                        r_rec           <= !r_cfg_local_en
                                           || ((r_da & r_cfg_mask) != (r_cfg_base & r_cfg_mask));
                        r_m1            <= 1'b0;
                        r_m2            <= 1'b0;
                        r_sfree_found   <= 1'b0;
                        r_idx           <= '0;
                        r_state         <= S_S_RD;
                    end
                end
                S_S_RD: r_state <= S_S_CK;
                S_S_CK: begin
                    if (w_srd.valid && w_srd.flow == r_f && w_srd.tsval == r_tsv) begin
                        r_m1 <= 1'b1;
                    end
                    if (!w_srd.valid && !r_sfree_found) begin
                        r_sfree_found <= 1'b1;
                        r_sfree       <= r_idx;
                    end
                    if (w_srd.valid && r_r_found && w_srd.flow == r_r
                        && w_srd.tsval == r_ecr && !r_m2) begin
                        r_m2 <= 1'b1;
                        r_s  <= r_idx;
                        r_sw <= w_srd;
                    end
                    if (w_stamp_last) begin
                        r_state <= S_S_DEC;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_S_RD;
                    end
                end
                S_S_DEC: begin
                    r_ins <= w_ins;
                    if (w_special) begin
                        r_s      <= r_sfree;
                        r_sw     <= w_ns;
                        r_sample <= 1'b1;
                    end else begin
                        r_sample <= r_r_found && r_m2 && !r_sw.used;
                    end
                    r_state <= S_WR_NS;
                end
                S_WR_NS: r_state <= S_RTT;
                S_RTT: begin
                    if (r_now > r_sw.stime) begin
                        r_rtt <= w_ovl ? 32'hFFFF_FFFF : w_diff[31:0];
                    end else begin
                        r_rtt <= 32'd0;
                    end
                    r_state <= r_sample ? S_SMP : S_WR_F;
                end
                S_SMP: begin
                    r_res_status         <= rtm_pkg::ST_RTT;
                    r_res_rtt            <= r_rtt;
                    r_res_min            <= w_min;
                    r_res_fwd            <= r_sw.fwd_bytes;
                    r_res_dep            <= r_sw.dep_bytes;
                    r_res_since          <= r_arr - r_fw.bytes_at_sample;
                    r_fw.min_rtt         <= w_min;
                    r_fw.bytes_at_sample <= r_arr;
                    if (r_r == r_f) begin
                        r_fw.bytes_departed <= r_sw.fwd_bytes;
                    end else begin
                        r_rw.bytes_departed <= r_sw.fwd_bytes;
                        r_rw_dirty          <= 1'b1;
                    end
                    r_state <= S_WR_F;
                end
                S_WR_F: r_state <= S_WR_R;
                S_WR_R: r_state <= S_DONE;
                S_CF_RD: r_state <= S_CF_CK;
                S_CF_CK: begin
                    if (w_fkill) begin
                        if (r_flow_count != '0) begin
                            r_flow_count <= r_flow_count - 1'b1;
                        end
                        r_removed <= r_removed + 1'b1;
                    end
                    if (w_flow_last) begin
                        r_idx   <= '0;
                        r_state <= S_CS_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CF_RD;
                    end
                end
                S_CS_RD: r_state <= S_CS_CK;
                S_CS_CK: begin
                    r_sw <= w_srd;
                    if (w_srd.valid) begin
                        r_state <= S_CS_CK2;
                    end else if (w_stamp_last) begin
                        r_res_status <= rtm_pkg::ST_CLEANUP;
                        r_state      <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CS_RD;
                    end
                end
                S_CS_CK2: begin
                    if (w_stamp_last) begin
                        r_res_status <= rtm_pkg::ST_CLEANUP;
                        r_state      <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_CS_RD;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (!r_o_valid || i_ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_slot    <= r_res_slot;
                        r_o_rtt     <= r_res_rtt;
                        r_o_min     <= r_res_min;
                        r_o_fwd     <= r_res_fwd;
                        r_o_dep     <= r_res_dep;
                        r_o_since   <= r_res_since;
                        r_o_removed <= (r_res_status == rtm_pkg::ST_CLEANUP) ? r_removed : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready              = (r_state == S_IDLE);
    assign o_valid              = r_o_valid;
    assign o_status             = r_o_status;
    assign o_flow_slot          = r_o_slot;
    assign o_rtt_us             = r_o_rtt;
    assign o_min_rtt_us         = r_o_min;
    assign o_fwd_bytes          = r_o_fwd;
    assign o_departed_bytes     = r_o_dep;
    assign o_bytes_since_sample = r_o_since;
    assign o_removed_count      = r_o_removed;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flow_count <= CW'(rtm_pkg::FLOW_ENTRIES))
        else $error("flow count beyond table size");

    a_min_le_rtt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == rtm_pkg::ST_RTT) |-> (r_o_min <= r_o_rtt))
        else $error("flow minimum above the sample");

    a_removed_only_cleanup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != rtm_pkg::ST_CLEANUP) |-> (r_o_removed == '0))
        else $error("removed count outside a cleanup result");

endmodule

@@ sim/passive_tcp_rtt_matcher_tb.sv @@
// Self-checking testbench of the passive TCP RTT matcher: flow table, stamp table and aging.
module passive_tcp_rtt_matcher_tb;

    localparam longint CYCLE_LIMIT = 64'd130_000_000;

    typedef struct {
        logic        opcode;
        logic [47:0] now_us;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] ts_value;
        logic [31:0] ts_echo;
        logic        syn_only;
        logic        has_timestamp;
        logic [15:0] packet_length;
    } t_pkt;

    typedef struct {
        logic [2:0]  status;
        logic [9:0]  flow_slot;
        logic [31:0] rtt_us;
        logic [31:0] min_rtt_us;
        logic [47:0] fwd_bytes;
        logic [47:0] departed_bytes;
        logic [47:0] bytes_since_sample;
        logic [10:0] removed_count;
    } t_rtt_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_opcode = 1'b0;
    logic [47:0] i_now_us = '0;
    logic [31:0] i_src_ip = '0;
    logic [31:0] i_dst_ip = '0;
    logic [15:0] i_src_port = '0;
    logic [15:0] i_dst_port = '0;
    logic [31:0] i_ts_value = '0;
    logic [31:0] i_ts_echo = '0;
    logic        i_syn_only = 1'b0;
    logic        i_has_timestamp = 1'b0;
    logic [15:0] i_packet_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [9:0]  o_flow_slot;
    logic [31:0] o_rtt_us;
    logic [31:0] o_min_rtt_us;
    logic [47:0] o_fwd_bytes;
    logic [47:0] o_departed_bytes;
    logic [47:0] o_bytes_since_sample;
    logic [10:0] o_removed_count;

    passive_tcp_rtt_matcher u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow configuration
    logic        sh_local_en  = 1'b1;
    logic [31:0] sh_local_base = '0;
    logic [31:0] sh_local_mask = '0;
    logic [31:0] sh_stamp_age = 32'd10000000;
    logic [31:0] sh_flow_idle = 32'd300000000;
    logic [10:0] sh_flow_limit = 11'd1024;

    // Shadow flow table
    bit          fl_valid [rtm_pkg::FLOW_ENTRIES];
    logic [63:0] fl_addrs [rtm_pkg::FLOW_ENTRIES];
    logic [31:0] fl_ports [rtm_pkg::FLOW_ENTRIES];
    bit          fl_bidir [rtm_pkg::FLOW_ENTRIES];
    logic [47:0] fl_seen  [rtm_pkg::FLOW_ENTRIES];
    logic [31:0] fl_min   [rtm_pkg::FLOW_ENTRIES];
    logic [47:0] fl_sent  [rtm_pkg::FLOW_ENTRIES];
    logic [47:0] fl_at_smp[rtm_pkg::FLOW_ENTRIES];
    logic [47:0] fl_dep   [rtm_pkg::FLOW_ENTRIES];
    int          fl_count = 0;

    // Shadow stamp table
    bit          sp_valid[rtm_pkg::STAMP_ENTRIES];
    bit          sp_used [rtm_pkg::STAMP_ENTRIES];
    logic [9:0]  sp_flow [rtm_pkg::STAMP_ENTRIES];
    logic [31:0] sp_tsval[rtm_pkg::STAMP_ENTRIES];
    logic [47:0] sp_time [rtm_pkg::STAMP_ENTRIES];
    logic [47:0] sp_fwd  [rtm_pkg::STAMP_ENTRIES];
    logic [47:0] sp_dep  [rtm_pkg::STAMP_ENTRIES];

    t_pkt        pkt_pending[$];
    t_rtt_result rtt_expected[$];
    t_pkt        cur_pkt;
    int          n_queued = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    bit          quiet = 1'b0;
    int          src_gap = 0;
    int          sink_gap = 0;
    longint      cycles = 0;

    logic [31:0] hosts[4];
    logic [15:0] ports[3];
    logic [47:0] clock_us = 48'd1000;

    function automatic int find_flow(logic [63:0] a, logic [31:0] p);
        for (int i = 0; i < rtm_pkg::FLOW_ENTRIES; i++)
            if (fl_valid[i] && fl_addrs[i] == a && fl_ports[i] == p) return i;
        return -1;
    endfunction

    function automatic int find_stamp(int slot, logic [31:0] tsv);
        for (int i = 0; i < rtm_pkg::STAMP_ENTRIES; i++)
            if (sp_valid[i] && sp_flow[i] == slot[9:0] && sp_tsval[i] == tsv) return i;
        return -1;
    endfunction

    function automatic bit is_old(logic [47:0] now_v, logic [47:0] then_v, logic [31:0] lim);
        return (now_v > then_v) && ((now_v - then_v) > {16'd0, lim});
    endfunction

    function automatic t_rtt_result predict_rtt(t_pkt p);
        t_rtt_result r;
        logic [63:0] ka, ra;
        logic [31:0] kp, rp;
        int          f, rv, s, j, lim, removed;
        logic [48:0] sum;
        logic [47:0] arr, d;
        logic [31:0] rtt;
        r = '{default: '0};
        if (p.opcode) begin
            removed = 0;
            for (int i = 0; i < rtm_pkg::STAMP_ENTRIES; i++)
                if (sp_valid[i] && is_old(p.now_us, sp_time[i], sh_stamp_age)) sp_valid[i] = 0;
            for (int i = 0; i < rtm_pkg::FLOW_ENTRIES; i++)
                if (fl_valid[i] && is_old(p.now_us, fl_seen[i], sh_flow_idle)) begin
                    fl_valid[i] = 0;
                    if (fl_count > 0) fl_count--;
                    removed++;
                end
            // drop stamps of removed flows
            for (int i = 0; i < rtm_pkg::STAMP_ENTRIES; i++)
                if (sp_valid[i] && !fl_valid[sp_flow[i]]) sp_valid[i] = 0;
            r.status = rtm_pkg::ST_CLEANUP;
            r.removed_count = removed[10:0];
            return r;
        end
        if (!p.has_timestamp) begin
            r.status = rtm_pkg::ST_NO_TS;
            return r;
        end
        if (p.ts_value == 0 || (p.ts_echo == 0 && !p.syn_only)) begin
            r.status = rtm_pkg::ST_IGNORED;
            return r;
        end
        ka = {p.src_ip, p.dst_ip};
        ra = {p.dst_ip, p.src_ip};
        kp = {p.src_port, p.dst_port};
        rp = {p.dst_port, p.src_port};
        f = find_flow(ka, kp);
        if (f < 0) begin
            lim = (sh_flow_limit > rtm_pkg::FLOW_ENTRIES) ? rtm_pkg::FLOW_ENTRIES
                                                          : int'(sh_flow_limit);
            if (fl_count >= lim) begin
                r.status = rtm_pkg::ST_FULL;
                return r;
            end
            j = 0;
            while (j < rtm_pkg::FLOW_ENTRIES && fl_valid[j]) j++;
            if (j >= rtm_pkg::FLOW_ENTRIES) begin
                r.status = rtm_pkg::ST_FULL;
                return r;
            end
            f = j;
            fl_valid[f] = 1;
            fl_addrs[f] = ka;
            fl_ports[f] = kp;
            fl_bidir[f] = 0;
            fl_min[f] = '1;
            fl_sent[f] = '0;
            fl_at_smp[f] = '0;
            fl_dep[f] = '0;
            fl_count++;
            rv = find_flow(ra, rp);
            if (rv >= 0) begin
                fl_bidir[rv] = 1;
                fl_bidir[f] = 1;
            end
        end
        fl_seen[f] = p.now_us;
        r.flow_slot = f[9:0];
        if (!fl_bidir[f]) begin
            r.status = rtm_pkg::ST_UNIDIR;
            return r;
        end
        sum = {1'b0, fl_sent[f]} + {33'd0, p.packet_length};
        arr = sum[48] ? '1 : sum[47:0];
        fl_sent[f] = arr;
        if (!sh_local_en || (p.dst_ip & sh_local_mask) != (sh_local_base & sh_local_mask)) begin
            if (find_stamp(f, p.ts_value) < 0) begin
                j = 0;
                while (j < rtm_pkg::STAMP_ENTRIES && sp_valid[j]) j++;
                if (j < rtm_pkg::STAMP_ENTRIES) begin
                    sp_valid[j] = 1;
                    sp_used[j] = 0;
                    sp_flow[j] = f[9:0];
                    sp_tsval[j] = p.ts_value;
                    sp_time[j] = p.now_us;
                    sp_fwd[j] = arr;
                    sp_dep[j] = fl_dep[f];
                end
            end
        end
        r.status = rtm_pkg::ST_NO_MATCH;
        rv = find_flow(ra, rp);
        if (rv < 0) return r;
        s = find_stamp(rv, p.ts_echo);
        if (s < 0 || sp_used[s]) return r;
        d = (p.now_us > sp_time[s]) ? p.now_us - sp_time[s] : '0;
        rtt = (d > 48'hFFFF_FFFF) ? '1 : d[31:0];
        if (fl_min[f] > rtt) fl_min[f] = rtt;
        r.status = rtm_pkg::ST_RTT;
        r.rtt_us = rtt;
        r.min_rtt_us = fl_min[f];
        r.fwd_bytes = sp_fwd[s];
        r.departed_bytes = sp_dep[s];
        r.bytes_since_sample = arr - fl_at_smp[f];
        fl_at_smp[f] = arr;
        fl_dep[rv] = sp_fwd[s];
        sp_used[s] = 1;
        return r;
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                rtt_expected.insert(rtt_expected.size(), predict_rtt(cur_pkt));
            if (!(i_valid && !o_ready)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    src_gap <= $urandom_range(0, 17);
                    i_valid <= 1'b0;
                end else if (pkt_pending.size() > 0) begin
                    cur_pkt = pkt_pending.pop_front();
                    i_opcode        <= cur_pkt.opcode;
                    i_now_us        <= cur_pkt.now_us;
                    i_src_ip        <= cur_pkt.src_ip;
                    i_dst_ip        <= cur_pkt.dst_ip;
                    i_src_port      <= cur_pkt.src_port;
                    i_dst_port      <= cur_pkt.dst_port;
                    i_ts_value      <= cur_pkt.ts_value;
                    i_ts_echo       <= cur_pkt.ts_echo;
                    i_syn_only      <= cur_pkt.syn_only;
                    i_has_timestamp <= cur_pkt.has_timestamp;
                    i_packet_length <= cur_pkt.packet_length;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        t_rtt_result e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (rtt_expected.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $realtime, o_status);
                    n_errors++;
                end else begin
                    e = rtt_expected.pop_front();
                    check_field("status", 48'(e.status), 48'(o_status));
                    check_field("flow_slot", 48'(e.flow_slot), 48'(o_flow_slot));
                    check_field("rtt_us", 48'(e.rtt_us), 48'(o_rtt_us));
                    check_field("min_rtt_us", 48'(e.min_rtt_us), 48'(o_min_rtt_us));
                    check_field("fwd_bytes", e.fwd_bytes, o_fwd_bytes);
                    check_field("departed_bytes", e.departed_bytes, o_departed_bytes);
                    check_field("bytes_since_sample", e.bytes_since_sample,
                                o_bytes_since_sample);
                    check_field("removed_count", 48'(e.removed_count), 48'(o_removed_count));
                end
                n_checked <= n_checked + 1;
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(0, 17);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_pkt(logic op, logic [47:0] now_v, logic [31:0] sa, logic [31:0] da,
                            logic [15:0] sp, logic [15:0] dp, logic [31:0] tsv,
                            logic [31:0] ecr, logic syn, logic hasts, logic [15:0] len);
        t_pkt p;
        p = '{op, now_v, sa, da, sp, dp, tsv, ecr, syn, hasts, len};
        pkt_pending.insert(pkt_pending.size(), p);
        n_queued++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            rtm_pkg::CFG_LOCAL_EN:   sh_local_en = val[0];
            rtm_pkg::CFG_LOCAL_BASE: sh_local_base = val;
            rtm_pkg::CFG_LOCAL_MASK: sh_local_mask = val;
            rtm_pkg::CFG_TS_AGE:     sh_stamp_age = val;
            rtm_pkg::CFG_FLOW_IDLE:  sh_flow_idle = val;
            rtm_pkg::CFG_FLOW_LIMIT: sh_flow_limit = val[10:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly flows among a few hosts with small TSvals so echoes match
    task automatic push_random(int n, int max_step);
        logic [31:0] sa, da, tsv, ecr;
        logic [15:0] sp, dp;
        logic [47:0] step;
        for (int k = 0; k < n; k++) begin
            step = 48'($urandom_range(0, max_step));
            if ($urandom_range(0, 59) == 0) step = {14'd0, 2'($urandom_range(0, 3)), 32'd0};
            clock_us = clock_us + step;
            if ($urandom_range(0, 79) == 0) clock_us = 48'({$urandom, $urandom});
            sa = hosts[$urandom_range(0, 3)];
            da = hosts[$urandom_range(0, 3)];
            sp = ports[$urandom_range(0, 2)];
            dp = ports[$urandom_range(0, 2)];
            if ($urandom_range(0, 24) == 0) begin
                sa = $urandom;
                da = $urandom;
                sp = 16'($urandom);
                dp = 16'($urandom);
            end
            tsv = $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) tsv = $urandom;
            if ($urandom_range(0, 29) == 0) tsv = 0;
            ecr = $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) ecr = $urandom;
            if ($urandom_range(0, 19) == 0) ecr = 0;
            push_pkt($urandom_range(0, 29) == 0, clock_us, sa, da, sp, dp, tsv, ecr,
                     $urandom_range(0, 7) == 0, $urandom_range(0, 19) != 0, 16'($urandom));
        end
    endtask

    task automatic drain;
        wait (n_checked == n_queued && pkt_pending.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        foreach (hosts[k]) hosts[k] = $urandom;
        foreach (ports[k]) ports[k] = 16'($urandom);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: everything is local, so nothing is ever recorded
        push_pkt(0, 48'd10, hosts[0], hosts[1], ports[0], ports[1], 1, 0, 1, 1, 100);
        push_pkt(0, 48'd20, hosts[1], hosts[0], ports[1], ports[0], 2, 1, 0, 1, 100);
        push_pkt(0, 48'd30, hosts[0], hosts[1], ports[0], ports[1], 3, 2, 0, 1, 100);
        drain();

        write_reg(rtm_pkg::CFG_LOCAL_EN, 32'd0);
        write_reg(rtm_pkg::CFG_LOCAL_BASE, 32'hFFFF_FFFF);
        write_reg(rtm_pkg::CFG_LOCAL_MASK, 32'hFFFF_FFFF);
        write_reg(rtm_pkg::CFG_TS_AGE, 32'd500);
        write_reg(rtm_pkg::CFG_FLOW_IDLE, 32'd3000);
        write_reg(rtm_pkg::CFG_FLOW_LIMIT, 32'd1024);
        // missing timestamp, zero TSval, zero echo without SYN
        push_pkt(0, 48'd100, hosts[2], hosts[3], ports[0], ports[1], 5, 5, 0, 0, 10);
        push_pkt(0, 48'd101, hosts[2], hosts[3], ports[0], ports[1], 0, 5, 0, 1, 10);
        push_pkt(0, 48'd102, hosts[2], hosts[3], ports[0], ports[1], 5, 0, 0, 1, 10);
        // SYN opens the flow, reply makes it bidirectional, then matches
        push_pkt(0, 48'd110, hosts[2], hosts[3], ports[0], ports[1], 7, 0, 1, 1, 60);
        push_pkt(0, 48'd150, hosts[3], hosts[2], ports[1], ports[0], 9, 7, 0, 1, 60);
        push_pkt(0, 48'd170, hosts[2], hosts[3], ports[0], ports[1], 8, 9, 0, 1, 16'hFFFF);
        push_pkt(0, 48'd200, hosts[3], hosts[2], ports[1], ports[0], 10, 8, 0, 1, 0);
        push_pkt(0, 48'd210, hosts[3], hosts[2], ports[1], ports[0], 11, 8, 0, 1, 1);
        // self-reverse flow
        push_pkt(0, 48'd220, hosts[1], hosts[1], ports[2], ports[2], 4, 4, 0, 1, 40);
        push_pkt(0, 48'd230, hosts[1], hosts[1], ports[2], ports[2], 5, 4, 0, 1, 40);
        // time going backwards clamps the sample
        push_pkt(0, 48'd240, hosts[2], hosts[3], ports[0], ports[1], 12, 10, 0, 1, 5);
        push_pkt(0, 48'd50, hosts[3], hosts[2], ports[1], ports[0], 13, 12, 0, 1, 5);
        // extreme field values
        push_pkt(0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 16'hFFFF);
        push_pkt(0, 48'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'd1, 32'd1, 0, 1, 16'd0);
        // tick ages out stamps; a later tick removes idle flows
        push_pkt(1, 48'd1000, '0, '0, '0, '0, '0, '0, 0, 1, '0);
        push_pkt(0, 48'd1100, hosts[2], hosts[3], ports[0], ports[1], 14, 13, 0, 1, 5);
        push_pkt(1, 48'd5000, '1, '1, '1, '1, '1, '1, 1, 0, '1);
        push_pkt(0, 48'd5100, hosts[3], hosts[2], ports[1], ports[0], 15, 14, 0, 1, 5);
        clock_us = 48'd6000;
        push_random(480, 120);
        drain();

        write_reg(rtm_pkg::CFG_FLOW_LIMIT, 32'd3);
        write_reg(rtm_pkg::CFG_LOCAL_EN, 32'd1);
        write_reg(rtm_pkg::CFG_LOCAL_BASE, hosts[1]);
        push_random(300, 120);
        drain();

        write_reg(rtm_pkg::CFG_FLOW_LIMIT, 32'd0);
        push_random(100, 120);
        drain();

        write_reg(rtm_pkg::CFG_FLOW_LIMIT, 32'd1024);
        write_reg(rtm_pkg::CFG_TS_AGE, 32'd0);
        write_reg(rtm_pkg::CFG_FLOW_IDLE, 32'hFFFF_FFFF);
        write_reg(rtm_pkg::CFG_LOCAL_MASK, 32'hFFFF_0000);
        write_reg(rtm_pkg::CFG_LOCAL_BASE, hosts[2]);
        push_random(400, 60);
        drain();

        write_reg(rtm_pkg::CFG_TS_AGE, 32'hFFFF_FFFF);
        write_reg(rtm_pkg::CFG_FLOW_IDLE, 32'd0);
        write_reg(rtm_pkg::CFG_LOCAL_EN, 32'd0);
        push_random(300, 2000);
        drain();

        write_reg(rtm_pkg::CFG_TS_AGE, 32'd2000);
        write_reg(rtm_pkg::CFG_FLOW_IDLE, 32'd20000);
        write_reg(rtm_pkg::CFG_FLOW_LIMIT, 32'd12);
        quiet = 1'b1;
        push_random(250, 200);
        wait (n_checked == n_queued && pkt_pending.size() == 0);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && rtt_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
